[sv/cbm_pkg.sv]
`default_nettype none
package cbm_pkg;

	localparam int ROM_ADDR_W = 21;
	localparam int ROM_OFFSET_W = 14;
	localparam int RAM_OFFSET_W = 13;

	localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd0;
	localparam logic [1:0] CFG_RAM_BANK_COUNT = 2'd1;

	localparam logic [1:0] CTL_RAM_ENABLE = 2'b00;
	localparam logic [1:0] CTL_ROM_BANK_LOW = 2'b01;
	localparam logic [1:0] CTL_UPPER_BITS = 2'b10;
	localparam logic [1:0] CTL_BANK_MODE = 2'b11;

	localparam logic [2:0] RAM_WINDOW = 3'b101;
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
	localparam logic [7:0] ROM_COUNT_RESET = 8'd2;
	localparam logic [7:0] LOW_BANK_LIMIT = 8'd31;
	localparam logic [7:0] OPEN_BUS = 8'hFF;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
		logic load_out;
	} cbm_cmd_t;

endpackage
`default_nettype wire

[sv/cbm_rem.sv]
`default_nettype none
module cbm_rem (
	input  wire logic       clk,
	input  wire logic       start,
	input  wire logic       step,
	input  wire logic [7:0] dividend,
	input  wire logic [7:0] divisor,
	output logic      [7:0] remainder
);
	localparam int STEPS = 4;

	logic [7:0] rem_q;
	logic [7:0] dvd_q;
	logic [7:0] dvs_q;
	logic [7:0] rem_nx;
	logic [7:0] dvd_nx;

	always_comb begin
		logic [8:0] trial;
		rem_nx = rem_q;
		dvd_nx = dvd_q;
		for (int i = 0; i < STEPS; i++) begin
			trial = {rem_nx, dvd_nx[7]};
			if (trial >= {1'b0, dvs_q}) begin
				trial = trial - {1'b0, dvs_q};
			end
			rem_nx = trial[7:0];
			dvd_nx = {dvd_nx[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (step) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_nx;
		end
	end

	assign remainder = rem_q;

endmodule
`default_nettype wire

[sv/cbm_datapath.sv]
`default_nettype none
module cbm_datapath #(
	parameter int MAX_RAM_BANKS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cbm_pkg::cbm_cmd_t             cmd,
	input  wire logic                          kind,
	input  wire logic [15:0]                   address,
	input  wire logic [7:0]                    write_data,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [7:0]                    cfg_data,
	output logic      [7:0]                    read_data,
	output logic      [cbm_pkg::ROM_ADDR_W-1:0] rom_address,
	output logic                               rom_hit,
	output logic                               ok
);
	import cbm_pkg::*;

	localparam int RAM_DEPTH = MAX_RAM_BANKS * (1 << RAM_OFFSET_W);
	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam logic [2:0] MAX_BANKS = 3'(MAX_RAM_BANKS);

	logic [7:0]  rom_count_q;
	logic [2:0]  ram_count_q;
	logic        ram_enable_q;
	logic [4:0]  rom_bank_low_q;
	logic [1:0]  upper_bits_q;
	logic        bank_mode_q;
	logic        kind_q;
	logic [15:0] addr_q;
	logic [7:0]  wdata_q;
	logic [7:0]  ram_q [RAM_DEPTH];
	logic [7:0]  ram_rd_q;

	logic [7:0]  rom_count_eff;
	logic [4:0]  low_bank;
	logic [6:0]  rom_bank;
	logic [7:0]  remainder;
	logic [2:0]  ram_count_eff;
	logic [1:0]  ram_bank;
	logic        ram_ok;
	logic [RAM_OFFSET_W+1:0] ram_index_full;
	logic [RAM_AW-1:0] ram_index;

	assign rom_count_eff = (rom_count_q == '0) ? 8'd1 : rom_count_q;
	assign low_bank = (rom_bank_low_q == '0) ? 5'd1 : rom_bank_low_q;

	always_comb begin
		if (!address[ROM_OFFSET_W]) begin
			rom_bank = bank_mode_q ? {upper_bits_q, 5'b0} : '0;
		end else if (rom_count_eff > LOW_BANK_LIMIT) begin
			rom_bank = {upper_bits_q, low_bank};
		end else begin
			rom_bank = {2'b00, low_bank};
		end
	end

	cbm_rem u_rem (
		.clk       (clk),
		.start     (cmd.start),
		.step      (cmd.step),
		.dividend  ({1'b0, rom_bank}),
		.divisor   (rom_count_eff),
		.remainder (remainder)
	);

	assign ram_count_eff = (ram_count_q > MAX_BANKS) ? MAX_BANKS : ram_count_q;
	assign ram_bank = (bank_mode_q && ({1'b0, upper_bits_q} < ram_count_eff)) ?
		upper_bits_q : 2'b00;
	assign ram_ok = ram_enable_q && (addr_q[15:13] == RAM_WINDOW) &&
		({1'b0, ram_bank} < ram_count_eff);
	assign ram_index_full = {ram_bank, addr_q[RAM_OFFSET_W-1:0]};
	assign ram_index = ram_index_full[RAM_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_count_q <= ROM_COUNT_RESET;
			ram_count_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROM_BANK_COUNT) begin
				rom_count_q <= cfg_data;
			end else if (cfg_index == CFG_RAM_BANK_COUNT) begin
				ram_count_q <= cfg_data[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q <= 1'b0;
			rom_bank_low_q <= '0;
			upper_bits_q <= '0;
			bank_mode_q <= 1'b0;
		end else if (cmd.commit && kind_q && !addr_q[15]) begin
			unique case (addr_q[14:13])
				CTL_RAM_ENABLE: begin
					ram_enable_q <= (wdata_q[3:0] == RAM_ENABLE_KEY);
				end
				CTL_ROM_BANK_LOW: begin
					rom_bank_low_q <= wdata_q[4:0];
				end
				CTL_UPPER_BITS: begin
					upper_bits_q <= wdata_q[1:0];
				end
				CTL_BANK_MODE: begin
					bank_mode_q <= wdata_q[0];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			addr_q <= address;
			wdata_q <= write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (ram_ok && kind_q) begin
				ram_q[ram_index] <= wdata_q;
			end
			ram_rd_q <= ram_q[ram_index];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (!addr_q[15]) begin
				read_data <= '0;
				ok <= 1'b1;
				rom_hit <= !kind_q;
				rom_address <= kind_q ? '0 : {remainder[6:0], addr_q[ROM_OFFSET_W-1:0]};
			end else if (ram_ok) begin
				read_data <= kind_q ? 8'd0 : ram_rd_q;
				ok <= 1'b1;
				rom_hit <= 1'b0;
				rom_address <= '0;
			end else begin
				read_data <= OPEN_BUS;
				ok <= 1'b0;
				rom_hit <= 1'b0;
				rom_address <= '0;
			end
		end
	end

endmodule
`default_nettype wire

[sv/cbm_ctrl.sv]
`default_nettype none
module cbm_ctrl (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	output cbm_pkg::cbm_cmd_t cmd
);
	import cbm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ITER1 = 4'b0010,
		S_ITER2 = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_FIN) && out_free);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.start = in_valid && in_ready;
		cmd.step = (state_q == S_ITER1) || (state_q == S_ITER2);
		cmd.commit = (state_q == S_ITER1);
		cmd.load_out = (state_q == S_FIN) && out_free;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_ITER1;
			end
			S_ITER1: begin
				state_nx = S_ITER2;
			end
			S_ITER2: begin
				state_nx = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_nx = in_valid ? S_ITER1 : S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_start_iter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == S_ITER1))
		else $error("accepted item did not enter the first iteration");

	a_ready_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> ((state_q == S_IDLE) || (state_q == S_FIN)))
		else $error("input ready while an item is in progress");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

[sv/cartridge_bank_mapper.sv]
// Bank controller for a 16-bit cartridge bus.
// Each item on the input channel (in_valid/in_ready) is one bus access: kind,
// address and write_data. Each access yields exactly one item on the output
// channel (out_valid/out_ready): read_data, rom_address, rom_hit and ok.
// Writes below 0x8000 load the control registers, reads below 0x8000 return
// a translated ROM address, and accesses at 0xA000-0xBFFF reach the banked
// RAM held inside the block.
// The configuration channel (cfg_valid/cfg_ready, always ready) sets the ROM
// bank count (index 0) and the RAM bank count (index 1); the user must write
// it only while no access is in progress, which the block does not enforce.
// A new access is taken in the final state of the previous one, once the
// output register is free. The bank reduction by the configured ROM bank
// count runs in a remainder unit retiring four quotient bits per cycle over
// the iteration states, and the RAM read fills a registered read port in
// parallel. When the receiver stalls, the result waits in the output register
// and the following access holds in its final state until that register frees.
// Reset clears the control registers and the bank counts to their defaults;
// the RAM contents stay undefined until written.
`default_nettype none
module cartridge_bank_mapper #(
	parameter int MAX_RAM_BANKS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  read_data,
	output logic      [cbm_pkg::ROM_ADDR_W-1:0] rom_address,
	output logic             rom_hit,
	output logic             ok,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import cbm_pkg::*;

	cbm_cmd_t cmd;

	assign cfg_ready = 1'b1;

	cbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	cbm_datapath #(
		.MAX_RAM_BANKS (MAX_RAM_BANKS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.address     (address),
		.write_data  (write_data),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.read_data   (read_data),
		.rom_address (rom_address),
		.rom_hit     (rom_hit),
		.ok          (ok)
	);

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
	import cbm_pkg::*;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;
	localparam int unsigned ROM_BANK_BYTES = 16384;
	localparam int unsigned RAM_BANK_BYTES = 8192;
	localparam int unsigned MAPPED_RAM_BANKS = 4;
	localparam int unsigned PHASE_COUNT = 7;
	localparam int unsigned PHASE_ITEMS = 250;
	localparam int unsigned PAUSE_ITEM = 120;
	localparam int unsigned LONG_HOLD_CYCLES = 400;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        drain;
	} bus_access_t;

	typedef struct packed {
		logic [7:0]            read_data;
		logic [ROM_ADDR_W-1:0] rom_address;
		logic                  rom_hit;
		logic                  ok;
	} bus_result_t;

	typedef struct packed {
		logic       ram_en;
		logic [4:0] bank_low;
		logic [1:0] upper;
		logic       mode;
		logic [7:0] rom_count;
		logic [2:0] ram_count;
	} mapper_regs_t;

	typedef struct packed {
		logic        hit;
		logic [14:0] index;
	} ram_lookup_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [15:0] address = '0;
	logic [7:0] write_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] read_data;
	logic [ROM_ADDR_W-1:0] rom_address;
	logic rom_hit;
	logic ok;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	bus_access_t pending_accesses [$];
	bus_result_t expected_results [$];
	mapper_regs_t live_regs;
	mapper_regs_t plan_regs;
	logic [7:0] ram_image [0:32767];
	bit ram_written [0:32767];
	int unsigned offered_count = 0;
	int unsigned sent_count = 0;
	int unsigned cfg_count = 0;
	int unsigned fail_count = 0;
	int unsigned sender_idle_pct = 25;
	int unsigned receiver_idle_pct = 64;
	int unsigned hold_left = 0;
	bit want_long_hold = 1'b0;
	bit long_hold_started = 1'b0;

	cartridge_bank_mapper u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.address(address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.rom_address(rom_address),
		.rom_hit(rom_hit),
		.ok(ok),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic logic [ROM_ADDR_W-1:0] rom_byte_address(mapper_regs_t r,
			logic [15:0] a);
		int unsigned count;
		int unsigned bank;
		count = (r.rom_count == 0) ? 1 : r.rom_count;
		if (a < 16'h4000) begin
			bank = r.mode ? {r.upper, 5'd0} : 0;
		end else begin
			bank = (r.bank_low == 0) ? 1 : r.bank_low;
			if (count > LOW_BANK_LIMIT)
				bank = bank | {r.upper, 5'd0};
		end
		return ROM_ADDR_W'((bank % count) * ROM_BANK_BYTES + a[13:0]);
	endfunction

	function automatic ram_lookup_t ram_slot(mapper_regs_t r, logic [15:0] a);
		ram_lookup_t look;
		int unsigned count;
		int unsigned bank;
		look.hit = 1'b0;
		look.index = '0;
		count = (r.ram_count > MAPPED_RAM_BANKS) ? MAPPED_RAM_BANKS : r.ram_count;
		bank = (r.mode && r.upper < count) ? r.upper : 0;
		if (a[15:13] == RAM_WINDOW && r.ram_en && bank < count) begin
			look.hit = 1'b1;
			look.index = 15'(bank * RAM_BANK_BYTES + a[12:0]);
		end
		return look;
	endfunction

	function automatic mapper_regs_t apply_control(mapper_regs_t r, logic [15:0] a,
			logic [7:0] d);
		case (a[14:13])
			CTL_RAM_ENABLE: r.ram_en = (d[3:0] == RAM_ENABLE_KEY);
			CTL_ROM_BANK_LOW: r.bank_low = d[4:0];
			CTL_UPPER_BITS: r.upper = d[1:0];
			CTL_BANK_MODE: r.mode = d[0];
		endcase
		return r;
	endfunction

	function automatic mapper_regs_t apply_config(mapper_regs_t r, logic [1:0] index,
			logic [7:0] value);
		case (index)
			CFG_ROM_BANK_COUNT: r.rom_count = value;
			CFG_RAM_BANK_COUNT: r.ram_count = value[2:0];
			default: ;
		endcase
		return r;
	endfunction

	task automatic predict_access(input bus_access_t acc);
		bus_result_t res;
		ram_lookup_t look;
		res.read_data = OPEN_BUS;
		res.rom_address = '0;
		res.rom_hit = 1'b0;
		res.ok = 1'b0;
		look = ram_slot(live_regs, acc.address);
		if (!acc.address[15]) begin
			res.ok = 1'b1;
			res.read_data = '0;
			if (acc.kind == KIND_WRITE) begin
				live_regs = apply_control(live_regs, acc.address, acc.write_data);
			end else begin
				res.rom_hit = 1'b1;
				res.rom_address = rom_byte_address(live_regs, acc.address);
			end
		end else if (look.hit) begin
			res.ok = 1'b1;
			if (acc.kind == KIND_WRITE) begin
				ram_image[look.index] = acc.write_data;
				res.read_data = '0;
			end else begin
				res.read_data = ram_image[look.index];
			end
		end
		expected_results.push_back(res);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// A read of a RAM byte that was never written is turned into a write.
	task automatic queue_access(input logic k, input logic [15:0] a, input logic [7:0] d,
			input bit drain);
		bus_access_t acc;
		ram_lookup_t look;
		look = ram_slot(plan_regs, a);
		if (k == KIND_READ && look.hit && !ram_written[look.index])
			k = KIND_WRITE;
		if (k == KIND_WRITE) begin
			if (!a[15])
				plan_regs = apply_control(plan_regs, a, d);
			else if (look.hit)
				ram_written[look.index] = 1'b1;
		end
		acc.kind = k;
		acc.address = a;
		acc.write_data = d;
		acc.drain = drain;
		pending_accesses.push_back(acc);
	endtask

	task automatic queue_random_access(input bit drain);
		int unsigned pick;
		logic [15:0] a;
		logic [7:0] d;
		logic k;
		logic [12:0] offset;
		pick = $urandom_range(99);
		d = 8'($urandom);
		k = 1'($urandom);
		case ($urandom_range(3))
			0, 1: offset = 13'($urandom_range(15));
			2: offset = 13'h1FF0 | 13'($urandom_range(15));
			default: offset = 13'($urandom);
		endcase
		if (pick < 30) begin
			k = KIND_READ;
			a = 16'($urandom_range(16'h7FFF));
		end else if (pick < 55) begin
			k = KIND_WRITE;
			a = 16'($urandom_range(16'h7FFF));
			if (a[14:13] == CTL_RAM_ENABLE && $urandom_range(3) != 0)
				d[3:0] = RAM_ENABLE_KEY;
		end else if (pick < 85) begin
			a = {RAM_WINDOW, offset};
		end else begin
			a = 16'($urandom);
		end
		queue_access(k, a, d, drain);
	endtask

	task automatic write_config(input logic [1:0] index, input logic [7:0] value);
		int unsigned taken;
		taken = cfg_count;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		while (cfg_count == taken)
			@(negedge clk);
		cfg_valid <= 1'b0;
		plan_regs = apply_config(plan_regs, index, value);
	endtask

	task automatic wait_idle();
		while (pending_accesses.size() > 0 || sent_count != offered_count
				|| expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin : drive_bus
		bus_access_t head;
		if (!in_valid || sent_count == offered_count) begin
			if (pending_accesses.size() > 0)
				head = pending_accesses[0];
			if (arst_n && pending_accesses.size() > 0
					&& $urandom_range(99) >= sender_idle_pct
					&& !(head.drain && expected_results.size() > 0)) begin
				head = pending_accesses.pop_front();
				kind <= head.kind;
				address <= head.address;
				write_data <= head.write_data;
				in_valid <= 1'b1;
				offered_count++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (want_long_hold && !long_hold_started) begin
			long_hold_started = 1'b1;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin : watch_bus
		bus_result_t want;
		bus_access_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none outstanding: data %0h rom %0h hit %0b ok %0b",
						$time, read_data, rom_address, rom_hit, ok);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", want.read_data, read_data);
					check_field("rom_address", want.rom_address, rom_address);
					check_field("rom_hit", want.rom_hit, rom_hit);
					check_field("ok", want.ok, ok);
				end
			end
			if (cfg_valid && cfg_ready) begin
				live_regs = apply_config(live_regs, cfg_index, cfg_data);
				cfg_count++;
			end
			if (in_valid && in_ready) begin
				seen.kind = kind;
				seen.address = address;
				seen.write_data = write_data;
				seen.drain = 1'b0;
				predict_access(seen);
				sent_count++;
			end
		end
	end

	initial begin : run_test
		mapper_regs_t reset_regs;
		int unsigned p;
		int unsigned n;
		logic [7:0] rom_cnt;
		logic [2:0] ram_cnt;
		reset_regs = '0;
		reset_regs.rom_count = ROM_COUNT_RESET;
		live_regs = reset_regs;
		plan_regs = reset_regs;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_access(KIND_READ, 16'h0000, 8'h00, 1'b0);
		queue_access(KIND_READ, 16'h7FFF, 8'hFF, 1'b0);
		queue_access(KIND_WRITE, 16'hA000, 8'h55, 1'b0);
		queue_access(KIND_READ, 16'hBFFF, 8'h00, 1'b0);
		queue_access(KIND_READ, 16'h8000, 8'h00, 1'b0);
		queue_access(KIND_WRITE, 16'h9FFF, 8'hFF, 1'b0);
		queue_access(KIND_READ, 16'hC000, 8'h00, 1'b0);
		queue_access(KIND_WRITE, 16'hFFFF, 8'hAA, 1'b0);
		queue_access(KIND_WRITE, 16'h0000, 8'h0A, 1'b0);
		queue_access(KIND_WRITE, 16'hA123, 8'h77, 1'b0);
		queue_access(KIND_WRITE, 16'h3FFF, 8'hFF, 1'b0);
		queue_access(KIND_WRITE, 16'h5FFF, 8'hFF, 1'b0);
		queue_access(KIND_WRITE, 16'h7FFF, 8'hFF, 1'b0);
		queue_access(KIND_READ, 16'h3FFF, 8'h00, 1'b0);
		queue_access(KIND_READ, 16'h4000, 8'h00, 1'b0);
		wait_idle();

		// A ROM bank count of zero and a RAM bank count above the maximum.
		write_config(CFG_ROM_BANK_COUNT, 8'd0);
		write_config(CFG_RAM_BANK_COUNT, 8'd7);
		queue_access(KIND_READ, 16'h4000, 8'h00, 1'b0);
		queue_access(KIND_WRITE, 16'hBFFF, 8'hFF, 1'b0);
		queue_access(KIND_READ, 16'hBFFF, 8'h00, 1'b0);
		queue_access(KIND_WRITE, 16'h1FFF, 8'hF5, 1'b0);
		queue_access(KIND_READ, 16'hBFFF, 8'h00, 1'b0);
		queue_access(KIND_WRITE, 16'h0000, 8'h1A, 1'b0);
		queue_access(KIND_WRITE, 16'h6000, 8'h00, 1'b0);
		queue_access(KIND_WRITE, 16'h2000, 8'h00, 1'b0);
		queue_access(KIND_WRITE, 16'hA000, 8'h00, 1'b0);
		queue_access(KIND_READ, 16'hA000, 8'h00, 1'b0);
		wait_idle();

		for (p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin rom_cnt = 8'd128; ram_cnt = 3'd4; end
				1: begin rom_cnt = 8'd255; ram_cnt = 3'd7; end
				2: begin rom_cnt = 8'd1; ram_cnt = 3'd1; end
				3: begin rom_cnt = 8'd32; ram_cnt = 3'd2; end
				4: begin rom_cnt = 8'd31; ram_cnt = 3'd3; end
				5: begin rom_cnt = 8'd2; ram_cnt = 3'd5; end
				default: begin
					rom_cnt = 8'($urandom_range(2, 128));
					ram_cnt = 3'($urandom_range(4));
				end
			endcase
			if (p < 3) begin
				sender_idle_pct = 25;
				receiver_idle_pct = 64;
			end else if (p < 5) begin
				sender_idle_pct = 64;
				receiver_idle_pct = 25;
			end else begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			write_config(CFG_ROM_BANK_COUNT, rom_cnt);
			write_config(CFG_RAM_BANK_COUNT, {5'd0, ram_cnt});
			for (n = 0; n < PHASE_ITEMS; n++)
				queue_random_access(n == PAUSE_ITEM);
			if (p == 5)
				want_long_hold = 1'b1;
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
sv/cbm_pkg.sv
sv/cbm_rem.sv
sv/cbm_datapath.sv
sv/cbm_ctrl.sv
sv/cartridge_bank_mapper.sv
tb/tb_top.sv
